// File: design/lkv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic       OP_GET    = 1'b0;
   localparam logic       OP_PUT    = 1'b1;
   localparam logic [4:0] CAP_RESET = 5'd16;

   // One slot of the recency-ordered row
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } slot_type;

   // Per-cell control from the top level
   typedef struct packed {
      logic load;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: design/lkv_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_cell
// One slot of the cache row: holds a key/value entry, compares it against the
// lookup key and loads the entry of its upstream neighbor when told to.
// ----------------------------------------------------------------------------
module lkv_cell
   import lkv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctrl_type    ctrl,
   input  wire logic [KEY_W-1:0] lookup_key,
   input  wire slot_type         prev_slot,
   output slot_type              slot,
   output logic                  match
);

   logic              valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         key_ff  <= prev_slot.key;
         data_ff <= prev_slot.data;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.key   = key_ff;
   assign slot.data  = data_ff;
   assign match      = valid_ff && (key_ff == lookup_key);

endmodule
`default_nettype wire

// File: design/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement,
// built as a row of cells kept in recency order (cell 0 most recent).
// ----------------------------------------------------------------------------
//  channel  direction  signals                       contents
//  req      in         req_tvalid/tready/tdata/tuser  get or put item
//  rsp      out        rsp_tvalid/tready/tdata/tuser  hit flag and read value
//  csr      in         csr_wr_en/csr_wr_data          capacity register
//
// One item per cycle while the output register is free: every cell compares
// its key in the same cycle and the cells up to the hit or insert position
// load from their neighbor at the accepting edge. The result sits in an output
// register, so req_tready stays high while that register is empty or being
// taken. Reset clears the valid bits and the fill count; capacity resets to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [63:0]      req_tdata,   // key[31:0], write_value[63:32]
   input  wire logic             req_tuser,   // operation[0]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [31:0]           rsp_tdata,   // read_value[31:0]
   output logic                  rsp_tuser,   // hit[0]
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [CAP_W-1:0]       capacity_ff;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [DATA_W-1:0]      rsp_data_ff;

   logic                   accept;
   logic                   op;
   logic [KEY_W-1:0]       in_key;
   logic [DATA_W-1:0]      in_value;
   logic [CNT_W-1:0]       cap_eff;
   logic [CNT_W-1:0]       occ_trim;
   logic [CNT_W-1:0]       pos;
   logic                   hit;
   logic                   insert;
   logic                   shift;
   logic [MAX_ENTRIES-1:0] match;
   logic [CNT_W-1:0]       hit_pos;
   logic [DATA_W-1:0]      hit_data;
   slot_type               new_slot;
   slot_type               slots [MAX_ENTRIES];
   cell_ctrl_type          ctrl  [MAX_ENTRIES];

   assign op       = req_tuser;
   assign in_key   = req_tdata[31:0];
   assign in_value = req_tdata[63:32];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Keys are unique in the row, so at most one cell matches
   always_comb begin
      hit_pos  = '0;
      hit_data = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_pos  = hit_pos  | ({CNT_W{match[i]}} & CNT_W'(i));
         hit_data = hit_data | ({DATA_W{match[i]}} & slots[i].data);
      end
   end
   assign hit = |match;

   always_comb begin
      if (32'(capacity_ff) > MAX_ENTRIES) begin
         cap_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CNT_W'(capacity_ff);
      end
   end

   // Full store: drop the least recent entry by overwriting its slot
   assign occ_trim = (occ_ff >= cap_eff && occ_ff != '0) ? occ_ff - 1'b1 : occ_ff;
   assign insert   = (op == OP_PUT) && !hit && (cap_eff != '0);
   assign pos      = hit ? hit_pos : occ_trim;
   assign shift    = accept && (hit || insert);
   assign occ_in   = (accept && insert) ? occ_trim + 1'b1 : occ_ff;

   assign new_slot.valid = 1'b1;
   assign new_slot.key   = in_key;
   assign new_slot.data  = (op == OP_PUT) ? in_value : hit_data;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      assign ctrl[g].load = shift && (CNT_W'(g) <= pos);
      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl[g]),
         .lookup_key (in_key),
         .prev_slot  ((g == 0) ? new_slot : slots[(g == 0) ? 0 : g - 1]),
         .slot       (slots[g]),
         .match      (match[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff <= hit;
         if (op == OP_PUT) begin
            rsp_data_ff <= '0;
         end else if (hit) begin
            rsp_data_ff <= hit_data;
         end else begin
            rsp_data_ff <= '1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives gets and puts into the LRU key/value cache and mirrors the store
// in a recency-ordered array. Each result is matched against the oldest
// expected hit flag and read value. The capacity is moved through zero,
// small, default and oversized settings. Sender bursts and receiver stalls
// vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
   import lkv_pkg::*;

   localparam int          SLOTS       = 16;
   localparam int          POOL_SIZE   = 20;
   localparam int          QUIET_LIMIT = 2000;
   localparam logic [31:0] MISS_VALUE  = 32'hFFFF_FFFF;
   localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;

   // Receiver stall styles
   localparam logic [1:0] STALL_NONE    = 2'd0;
   localparam logic [1:0] STALL_RANDOM  = 2'd1;
   localparam logic [1:0] STALL_PATTERN = 2'd2;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
   } access_result_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [63:0]      req_tdata   = '0;   // key[31:0], write_value[63:32]
   logic             req_tuser   = 1'b0; // operation[0]
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [31:0]      rsp_tdata;          // read_value[31:0]
   logic             rsp_tuser;          // hit[0]
   logic             csr_wr_en   = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   // Mirror of the cache, slot 0 most recent
   logic [31:0]      mirror_key  [SLOTS];
   logic [31:0]      mirror_data [SLOTS];
   int               mirror_fill = 0;
   logic [CAP_W-1:0] mirror_cap  = CAP_RESET;

   access_result_type expected_access_results[$];
   logic [31:0]       key_pool [POOL_SIZE];

   int          error_count   = 0;
   int          items_sent    = 0;
   int          results_seen  = 0;
   int          hits_seen     = 0;
   int          evictions     = 0;
   int          cap_writes    = 0;
   int          quiet_cycles  = 0;
   int          burst_left    = 0;
   bit          sender_idles  = 1'b0;
   logic [1:0]  stall_mode    = STALL_NONE;
   logic [15:0] stall_pattern = 16'b1011_0111_1101_0110;

   lru_key_value_cache u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      case (stall_mode)
         STALL_RANDOM:  rsp_tready <= ($urandom_range(0, 2) != 0);
         STALL_PATTERN: rsp_tready <= stall_pattern[15];
         default:       rsp_tready <= 1'b1;
      endcase
   end

   // Shift slots 0..pos-1 down one place and put the entry at the front
   function automatic void move_to_front(int pos, logic [31:0] key, logic [31:0] data);
      int i;
      for (i = pos; i > 0; i--) begin
         mirror_key[i]  = mirror_key[i-1];
         mirror_data[i] = mirror_data[i-1];
      end
      mirror_key[0]  = key;
      mirror_data[0] = data;
   endfunction

   function automatic access_result_type predict_access(logic op, logic [31:0] key,
                                                        logic [31:0] write_value);
      access_result_type res;
      int                eff_cap;
      int                pos;
      int                i;
      bit                found;
      eff_cap = (mirror_cap > SLOTS) ? SLOTS : int'(mirror_cap);
      found   = 1'b0;
      pos     = 0;
      for (i = 0; i < mirror_fill; i++) begin
         if (!found && mirror_key[i] == key) begin
            found = 1'b1;
            pos   = i;
         end
      end
      res.hit = found;
      if (op == OP_GET) begin
         res.read_value = found ? mirror_data[pos] : MISS_VALUE;
         if (found) move_to_front(pos, key, mirror_data[pos]);
      end else begin
         res.read_value = '0;
         if (found) begin
            move_to_front(pos, key, write_value);
         end else if (eff_cap > 0) begin
            // Drop only the least recent entry, even if capacity was lowered
            if (mirror_fill >= eff_cap && mirror_fill > 0) begin
               mirror_fill--;
               evictions++;
            end
            move_to_front(mirror_fill, key, write_value);
            mirror_fill++;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      access_result_type exp_res;
      if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_access_results.size() == 0) begin
            $error("unexpected result: hit %0d read_value %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            exp_res = expected_access_results.pop_front();
            if (exp_res.hit) hits_seen++;
            if (rsp_tuser !== exp_res.hit) begin
               $error("hit: expected %0d, actual %0d", exp_res.hit, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== exp_res.read_value) begin
               $error("read_value: expected %h, actual %h", exp_res.read_value, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Called at a rising edge; returns at the edge that accepted the item
   // (or after the following gap) with tvalid still high when no gap follows.
   task automatic send_access(logic op, logic [31:0] key, logic [31:0] write_value);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {write_value, key};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      expected_access_results.push_back(predict_access(op, key, write_value));
      items_sent++;
      if (sender_idles) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 10);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Hold off until every result is back, then let the pipeline settle
   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_access_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mirror_cap = value;
      cap_writes++;
   endtask

   task automatic test_basic_lookup;
      stall_mode   = STALL_NONE;
      sender_idles = 1'b0;
      send_access(OP_GET, 32'h1234_5678, '0);
      send_access(OP_PUT, KEY_MIN, 32'h7FFF_FFFF);
      send_access(OP_PUT, KEY_MAX, 32'h8000_0000);
      send_access(OP_PUT, 32'h0, 32'h0);
      send_access(OP_GET, KEY_MIN, '0);
      send_access(OP_GET, KEY_MAX, 32'hFFFF_FFFF);
      send_access(OP_PUT, KEY_MAX, 32'hFFFF_FFFF);
      send_access(OP_GET, KEY_MAX, '0);
      // Keys one bit apart must not match
      send_access(OP_GET, KEY_MAX ^ 32'h1, '0);
      send_access(OP_GET, KEY_MIN ^ 32'h8000_0000 ^ 32'h1, '0);
   endtask

   task automatic test_zero_capacity;
      write_capacity(5'd0);
      stall_mode = STALL_PATTERN;
      send_access(OP_PUT, 32'hCAFE_0001, 32'h5555_AAAA);
      send_access(OP_GET, 32'hCAFE_0001, '0);
      send_access(OP_GET, KEY_MIN, '0);
      send_access(OP_PUT, KEY_MAX, 32'h0000_0001);
   endtask

   task automatic test_lowered_capacity;
      write_capacity(5'd1);
      stall_mode = STALL_RANDOM;
      send_access(OP_PUT, 32'hBEEF_0002, 32'h1357_9BDF);
      send_access(OP_GET, 32'h0, '0);
      send_access(OP_GET, KEY_MAX, '0);
      send_access(OP_GET, KEY_MIN, '0);
      send_access(OP_GET, 32'hBEEF_0002, '0);
   endtask

   task automatic run_random_phase(logic [CAP_W-1:0] cap, int count);
      int          span;
      int          eff_cap;
      logic [31:0] key;
      write_capacity(cap);
      stall_mode   = logic'($urandom_range(0, 2)) ? STALL_RANDOM : STALL_NONE;
      if ($urandom_range(0, 2) == 0) stall_mode = STALL_PATTERN;
      sender_idles = ($urandom_range(0, 3) != 0);
      eff_cap = (cap > SLOTS) ? SLOTS : int'(cap);
      span    = eff_cap + 4;
      if (span > POOL_SIZE) span = POOL_SIZE;
      repeat (count) begin
         // Reuse keys from a small pool so that hits and evictions are common
         if ($urandom_range(0, 9) < 7)
            key = key_pool[$urandom_range(0, span - 1)];
         else
            key = $urandom;
         send_access(logic'($urandom_range(0, 1)), key, $urandom);
      end
   endtask

   task automatic test_random_traffic;
      int i;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 32'h0;
      key_pool[3] = 32'hFFFF_FFFF;
      for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      run_random_phase(5'd16, 60);
      run_random_phase(5'd31, 60);
      run_random_phase(5'd1, 40);
      run_random_phase(5'd17, 50);
      run_random_phase(5'd0, 30);
      run_random_phase(5'd2, 40);
      run_random_phase(5'($urandom_range(3, 15)), 60);
      // Lower capacity while the store is full
      run_random_phase(5'd4, 60);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_lookup();
      test_zero_capacity();
      test_lowered_capacity();
      test_random_traffic();
      drain();
      $display("Sent %0d gets and puts over %0d capacity settings", items_sent, cap_writes);
      $display("Checked %0d results: %0d hits, %0d evictions", results_seen, hits_seen,
               evictions);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
